// ----- hdl/spid_pkg.sv -----
`default_nettype none

package spid_pkg;

  // Field and arithmetic widths.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int GAIN_W     = 16;
  localparam int LIM_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ERR_W  = COORD_BITS + 1;
  localparam int INT_W  = (COORD_BITS + 1 > LIM_W + 1) ? COORD_BITS + 1 : LIM_W + 1;
  localparam int ACC_W  = INT_W + 1;
  localparam int DER_W  = COORD_BITS + 2;
  localparam int MUL_W  = (INT_W > DER_W) ? INT_W : DER_W;
  localparam int PROD_W = GAIN_W + MUL_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHF_W  = SUM_W - FRAC_BITS;
  localparam int PC_W   = SHF_W + 1;

  typedef logic        [COORD_BITS-1:0] coord_t;
  typedef logic signed [GAIN_W-1:0]     gain_t;
  typedef logic        [LIM_W-1:0]      lim_t;
  typedef logic signed [ERR_W-1:0]      err_t;
  typedef logic signed [INT_W-1:0]      int_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [DER_W-1:0]      der_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [SHF_W-1:0]      shf_t;
  typedef logic signed [PC_W-1:0]       pc_t;

  // Bias added to a negative sum so that the shift truncates toward zero.
  localparam sum_t TRUNC_BIAS = sum_t'((1 << FRAC_BITS) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_I         = 3'd1,
    CFG_GAIN_D         = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_PULSE_MIN      = 3'd4,
    CFG_PULSE_MAX      = 3'd5
  } cfg_idx_e;

  localparam gain_t GAIN_P_RST         = 16'sd51;
  localparam gain_t GAIN_I_RST         = 16'sd0;
  localparam gain_t GAIN_D_RST         = 16'sd0;
  localparam lim_t  INTEGRAL_LIMIT_RST = 12'd1000;
  localparam lim_t  PULSE_MIN_RST      = 12'd500;
  localparam lim_t  PULSE_MAX_RST      = 12'd2050;

  typedef struct packed {
    gain_t gain_p;
    gain_t gain_i;
    gain_t gain_d;
    lim_t  integral_limit;
    lim_t  pulse_min;
    lim_t  pulse_max;
  } cfg_t;

  // Per-axis error terms handed from the front end to the multiply stage.
  typedef struct packed {
    err_t err;
    int_t integ;
    der_t deriv;
  } front_t;

endpackage

`default_nettype wire

// ----- hdl/spid_if.sv -----
`default_nettype none

interface spid_in_if;
  logic                 valid;
  logic                 ready;
  spid_pkg::coord_t     setpoint_x;
  spid_pkg::coord_t     setpoint_y;
  spid_pkg::coord_t     measured_x;
  spid_pkg::coord_t     measured_y;
  spid_pkg::coord_t     last_pulse_x;
  spid_pkg::coord_t     last_pulse_y;

  modport source (
    output valid, setpoint_x, setpoint_y, measured_x, measured_y, last_pulse_x, last_pulse_y,
    input  ready
  );
  modport sink (
    input  valid, setpoint_x, setpoint_y, measured_x, measured_y, last_pulse_x, last_pulse_y,
    output ready
  );
endinterface

interface spid_out_if;
  logic             valid;
  logic             ready;
  spid_pkg::coord_t pulse_x;
  spid_pkg::coord_t pulse_y;

  modport source (
    output valid, pulse_x, pulse_y,
    input  ready
  );
  modport sink (
    input  valid, pulse_x, pulse_y,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/two_axis_servo_pid.sv -----
// Two-axis servo PID. Each input item carries a target point, a measured point
// and the last X and Y servo pulses; each accepted item yields exactly one result
// item with the new X and Y pulses, in order. Per axis the block forms
// error = target - measured, adds it to an integral held within plus or minus
// integral_limit, takes derivative = error - previous error, and forms
// gain_p*error + gain_i*integral + gain_d*derivative with signed Q8.8 gains.
// The sum is divided by 256 with truncation toward zero. The X pulse moves by
// minus that amount and the Y pulse by plus it; each is raised to pulse_min and
// then capped at pulse_max. The block takes one item per clock cycle unless the
// output stalls with the pipeline full. Each accepted item passes four
// registers in order: an input register, an error/integral stage, a
// multiply-accumulate stage and the output register, which offers the result.
// Every stage has its own valid bit, so a stalled output only holds back the
// items behind it once the pipeline is full. Configuration registers are to be
// written through cfg_we_i / cfg_idx_i / cfg_wdata_i only while no item is in
// flight; the block does not enforce this. Writes to unused indexes are dropped.
// The integral and previous-error state of each axis resets to zero.
`default_nettype none

module two_axis_servo_pid (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [spid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [spid_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  spid_in_if.sink                              in_i,
  spid_out_if.source                           out_o
);

  spid_pkg::cfg_t cfg;

  spid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline handshake. Each stage may take a new item when it is empty or when
  // its current item is moving on in the same cycle.
  logic v0_q, v1_q, v2_q, v3_q;
  logic v0_d, v1_d, v2_d, v3_d;
  logic rdy1, rdy2, rdy3;
  logic adv0, adv1, adv2;
  logic in_acc;

  assign rdy3       = !v3_q || out_o.ready;
  assign adv2       = v2_q && rdy3;
  assign rdy2       = !v2_q || rdy3;
  assign adv1       = v1_q && rdy2;
  assign rdy1       = !v1_q || rdy2;
  assign adv0       = v0_q && rdy1;
  assign in_i.ready = !v0_q || rdy1;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    v0_d = in_acc ? 1'b1 : (adv0 ? 1'b0 : v0_q);
    v1_d = adv0   ? 1'b1 : (adv1 ? 1'b0 : v1_q);
    v2_d = adv1   ? 1'b1 : (adv2 ? 1'b0 : v2_q);
    v3_d = adv2   ? 1'b1 : (out_o.ready ? 1'b0 : v3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Input register.
  spid_pkg::coord_t tgt_x_q, tgt_y_q, meas_x_q, meas_y_q, last_x0_q, last_y0_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_x_q   <= in_i.setpoint_x;
      tgt_y_q   <= in_i.setpoint_y;
      meas_x_q  <= in_i.measured_x;
      meas_y_q  <= in_i.measured_y;
      last_x0_q <= in_i.last_pulse_x;
      last_y0_q <= in_i.last_pulse_y;
    end
  end

  // Error, integral and derivative. The axis state updates as the item moves
  // into stage one, so the next item sees it in the following cycle.
  spid_pkg::front_t front_x, front_y;

  spid_axis_front u_front_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .target_i   (tgt_x_q),
    .measured_i (meas_x_q),
    .limit_i    (cfg.integral_limit),
    .upd_i      (adv0),
    .front_o    (front_x)
  );

  spid_axis_front u_front_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .target_i   (tgt_y_q),
    .measured_i (meas_y_q),
    .limit_i    (cfg.integral_limit),
    .upd_i      (adv0),
    .front_o    (front_y)
  );

  spid_pkg::front_t fr_x_q, fr_y_q;
  spid_pkg::coord_t last_x1_q, last_y1_q;

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      fr_x_q    <= front_x;
      fr_y_q    <= front_y;
      last_x1_q <= last_x0_q;
      last_y1_q <= last_y0_q;
    end
  end

  // Gain products and the scaled PID correction.
  spid_pkg::shf_t corr_x, corr_y;

  spid_axis_mac u_mac_x (
    .front_i (fr_x_q),
    .cfg_i   (cfg),
    .corr_o  (corr_x)
  );

  spid_axis_mac u_mac_y (
    .front_i (fr_y_q),
    .cfg_i   (cfg),
    .corr_o  (corr_y)
  );

  spid_pkg::shf_t   corr_x_q, corr_y_q;
  spid_pkg::coord_t last_x2_q, last_y2_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      corr_x_q  <= corr_x;
      corr_y_q  <= corr_y;
      last_x2_q <= last_x1_q;
      last_y2_q <= last_y1_q;
    end
  end

  // New pulses: X moves against the correction, Y with it.
  spid_pkg::coord_t pulse_x, pulse_y;

  spid_pulse_clamp u_clamp_x (
    .last_i      (last_x2_q),
    .corr_i      (corr_x_q),
    .subtract_i  (1'b1),
    .pulse_min_i (cfg.pulse_min),
    .pulse_max_i (cfg.pulse_max),
    .pulse_o     (pulse_x)
  );

  spid_pulse_clamp u_clamp_y (
    .last_i      (last_y2_q),
    .corr_i      (corr_y_q),
    .subtract_i  (1'b0),
    .pulse_min_i (cfg.pulse_min),
    .pulse_max_i (cfg.pulse_max),
    .pulse_o     (pulse_y)
  );

  // Output register.
  spid_pkg::coord_t pulse_x_q, pulse_y_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      pulse_x_q <= pulse_x;
      pulse_y_q <= pulse_y;
    end
  end

  assign out_o.valid   = v3_q;
  assign out_o.pulse_x = pulse_x_q;
  assign out_o.pulse_y = pulse_y_q;

  // The integral handed into stage one stays within the limit in force when
  // it was computed.
  a_integ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(adv0) |->
      (spid_pkg::acc_t'(fr_x_q.integ) <= spid_pkg::acc_t'({1'b0, $past(cfg.integral_limit)}))
      && (spid_pkg::acc_t'(fr_x_q.integ) >= -spid_pkg::acc_t'({1'b0, $past(cfg.integral_limit)})))
    else $error("X integral outside its limit");

  // Back-to-back items: the derivative of the second is the difference of the
  // two errors, so the previous-error state was carried across correctly.
  a_deriv_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(adv0) && $past(adv0, 2) |->
      fr_y_q.deriv == spid_pkg::der_t'(fr_y_q.err) - spid_pkg::der_t'($past(fr_y_q.err)))
    else $error("Y derivative does not follow the previous error");

  // An item leaving the input register always lands in stage one.
  a_stage_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv0 |=> v1_q)
    else $error("item lost between input register and stage one");

endmodule

`default_nettype wire

// ----- hdl/spid_cfg_regs.sv -----
`default_nettype none

module spid_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [spid_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [spid_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output spid_pkg::cfg_t                          cfg_o
);

  spid_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (spid_pkg::cfg_idx_e'(cfg_idx_i))
        spid_pkg::CFG_GAIN_P:         cfg_d.gain_p         = spid_pkg::gain_t'(cfg_wdata_i);
        spid_pkg::CFG_GAIN_I:         cfg_d.gain_i         = spid_pkg::gain_t'(cfg_wdata_i);
        spid_pkg::CFG_GAIN_D:         cfg_d.gain_d         = spid_pkg::gain_t'(cfg_wdata_i);
        spid_pkg::CFG_INTEGRAL_LIMIT: cfg_d.integral_limit = spid_pkg::lim_t'(cfg_wdata_i);
        spid_pkg::CFG_PULSE_MIN:      cfg_d.pulse_min      = spid_pkg::lim_t'(cfg_wdata_i);
        spid_pkg::CFG_PULSE_MAX:      cfg_d.pulse_max      = spid_pkg::lim_t'(cfg_wdata_i);
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= spid_pkg::GAIN_P_RST;
      cfg_q.gain_i         <= spid_pkg::GAIN_I_RST;
      cfg_q.gain_d         <= spid_pkg::GAIN_D_RST;
      cfg_q.integral_limit <= spid_pkg::INTEGRAL_LIMIT_RST;
      cfg_q.pulse_min      <= spid_pkg::PULSE_MIN_RST;
      cfg_q.pulse_max      <= spid_pkg::PULSE_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- hdl/spid_axis_front.sv -----
`default_nettype none

module spid_axis_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spid_pkg::coord_t   target_i,
  input  wire spid_pkg::coord_t   measured_i,
  input  wire spid_pkg::lim_t     limit_i,
  input  wire logic               upd_i,
  output spid_pkg::front_t        front_o
);

  spid_pkg::int_t integ_q, integ_d;
  spid_pkg::err_t prev_q;
  spid_pkg::err_t err;
  spid_pkg::acc_t acc;
  spid_pkg::acc_t lim;
  spid_pkg::acc_t acc_clamped;

  always_comb begin
    err = spid_pkg::err_t'({1'b0, target_i}) - spid_pkg::err_t'({1'b0, measured_i});
    acc = spid_pkg::acc_t'(integ_q) + spid_pkg::acc_t'(err);
    lim = spid_pkg::acc_t'({1'b0, limit_i});
    if (acc > lim) begin
      acc_clamped = lim;
    end else if (acc < -lim) begin
      acc_clamped = -lim;
    end else begin
      acc_clamped = acc;
    end
    integ_d = spid_pkg::int_t'(acc_clamped);
  end

  assign front_o.err   = err;
  assign front_o.integ = integ_d;
  assign front_o.deriv = spid_pkg::der_t'(err) - spid_pkg::der_t'(prev_q);

  // Axis state moves forward only when the item is handed on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (upd_i) begin
      integ_q <= integ_d;
      prev_q  <= err;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/spid_axis_mac.sv -----
`default_nettype none

module spid_axis_mac (
  input  wire spid_pkg::front_t front_i,
  input  wire spid_pkg::cfg_t   cfg_i,
  output spid_pkg::shf_t        corr_o
);

  spid_pkg::prod_t prod_p, prod_i, prod_d;
  spid_pkg::sum_t  sum, sum_adj;

  always_comb begin
    prod_p  = spid_pkg::prod_t'(cfg_i.gain_p) * spid_pkg::prod_t'(front_i.err);
    prod_i  = spid_pkg::prod_t'(cfg_i.gain_i) * spid_pkg::prod_t'(front_i.integ);
    prod_d  = spid_pkg::prod_t'(cfg_i.gain_d) * spid_pkg::prod_t'(front_i.deriv);
    sum     = spid_pkg::sum_t'(prod_p) + spid_pkg::sum_t'(prod_i) + spid_pkg::sum_t'(prod_d);
    // A negative sum is biased up first so the arithmetic shift rounds toward zero.
    sum_adj = sum[spid_pkg::SUM_W-1] ? sum + spid_pkg::TRUNC_BIAS : sum;
    corr_o  = spid_pkg::shf_t'(sum_adj >>> spid_pkg::FRAC_BITS);
  end

endmodule

`default_nettype wire

// ----- hdl/spid_pulse_clamp.sv -----
`default_nettype none

module spid_pulse_clamp (
  input  wire spid_pkg::coord_t last_i,
  input  wire spid_pkg::shf_t   corr_i,
  input  wire logic             subtract_i,
  input  wire spid_pkg::lim_t   pulse_min_i,
  input  wire spid_pkg::lim_t   pulse_max_i,
  output spid_pkg::coord_t      pulse_o
);

  spid_pkg::pc_t base, corr, raw, lo, hi, lifted, limited;

  always_comb begin
    base    = spid_pkg::pc_t'({1'b0, last_i});
    corr    = spid_pkg::pc_t'(corr_i);
    raw     = subtract_i ? base - corr : base + corr;
    lo      = spid_pkg::pc_t'({1'b0, pulse_min_i});
    hi      = spid_pkg::pc_t'({1'b0, pulse_max_i});
    // Raise to the minimum first, then cap at the maximum; an inverted range
    // therefore always yields the maximum.
    lifted  = (raw < lo) ? lo : raw;
    limited = (lifted > hi) ? hi : lifted;
    pulse_o = spid_pkg::coord_t'(limited);
  end

endmodule

`default_nettype wire

// ----- verif/two_axis_servo_pid_tb.sv -----
`timescale 1ns / 100ps

// Self-checking testbench for the two-axis servo PID.
//
// Items go in through the input channel. At the edge where an item is
// accepted, a predictor in this module works out the two new pulse positions.
// It keeps its own copy of the per-axis integral, the previous error and the
// six configuration registers. These expected pulses are queued. Each result
// item accepted on the output channel is compared, field by field, with the
// oldest entry in that queue.
//
// The run opens with a few directed tests: reset values, integral clamping,
// pulse clamping (including an inverted pulse window), extreme gains, and
// register decode. After them come four random phases. Each phase uses its
// own pattern of sender gaps and receiver stalls, and loads two random
// register settings. Configuration is only written once the block has
// drained.
module two_axis_servo_pid_tb;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 3;
  // Idle wait after the last result is taken, before touching registers or
  // ending the run.
  localparam int DRAIN_CYCLES = 8;
  // With per-cycle gap and stall odds of at most 54 in a hundred, a correct run
  // essentially never goes this long without a handshake.
  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 150;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;

  // Register indexes that the block does not decode. Writes to them are dropped.
  localparam logic [spid_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [spid_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam spid_pkg::coord_t COORD_MAX = '1;

  typedef struct packed {
    spid_pkg::coord_t setpoint_x;
    spid_pkg::coord_t setpoint_y;
    spid_pkg::coord_t measured_x;
    spid_pkg::coord_t measured_y;
    spid_pkg::coord_t last_pulse_x;
    spid_pkg::coord_t last_pulse_y;
  } sample_t;

  typedef struct packed {
    spid_pkg::coord_t pulse_x;
    spid_pkg::coord_t pulse_y;
  } pulses_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [spid_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [spid_pkg::CFG_DATA_W-1:0] cfg_wdata;

  spid_in_if  in_if ();
  spid_out_if out_if ();

  two_axis_servo_pid DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if.sink),
    .out_o       (out_if.source)
  );

  // Shadow copy of the configuration registers, updated on each write edge.
  spid_pkg::gain_t kp, ki, kd;
  spid_pkg::lim_t  int_lim, pmin, pmax;

  // Per-axis controller state, indexed by AXIS_X / AXIS_Y.
  spid_pkg::err_t  prev_err [2];
  spid_pkg::int_t  integ [2];

  pulses_t expected_pulses [$];
  pulses_t last_expected;

  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  bit failed;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One axis of the controller. The integral is clamped to the symmetric limit
  // before it feeds the sum. The products are formed at full width, so the sum
  // is exact. Division by 2^FRAC_BITS on a longint truncates toward zero, as
  // the block does.
  function automatic longint pid_axis(input int ax, input spid_pkg::coord_t tgt,
                                      input spid_pkg::coord_t meas);
    longint err, acc, deriv, lim, sum;
    err   = longint'(tgt) - longint'(meas);
    acc   = longint'(integ[ax]) + err;
    deriv = err - longint'(prev_err[ax]);
    lim   = longint'(int_lim);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    integ[ax]    = spid_pkg::int_t'(acc);
    prev_err[ax] = spid_pkg::err_t'(err);
    sum = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * deriv;
    return sum / (longint'(1) << spid_pkg::FRAC_BITS);
  endfunction

  // Raise to pulse_min first, then cap at pulse_max. An inverted window
  // therefore always gives pulse_max.
  function automatic spid_pkg::coord_t clamp_pulse(input longint v);
    if (v < longint'(pmin)) v = longint'(pmin);
    if (v > longint'(pmax)) v = longint'(pmax);
    if (v < 0) v = 0;
    return spid_pkg::coord_t'(v);
  endfunction

  // The X servo moves against the controller output and the Y servo with it.
  function automatic pulses_t predict_pulses(input sample_t s);
    pulses_t r;
    longint  move_x, move_y;
    move_x    = pid_axis(AXIS_X, s.setpoint_x, s.measured_x);
    move_y    = pid_axis(AXIS_Y, s.setpoint_y, s.measured_y);
    r.pulse_x = clamp_pulse(longint'(s.last_pulse_x) - move_x);
    r.pulse_y = clamp_pulse(longint'(s.last_pulse_y) + move_y);
    return r;
  endfunction

  // Mirrors a register write. Bits above a register's width are dropped, and
  // so are writes to indexes that the block does not decode.
  function automatic void shadow_reg_write(input logic [spid_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [spid_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      spid_pkg::CFG_GAIN_P:         kp      = spid_pkg::gain_t'(data);
      spid_pkg::CFG_GAIN_I:         ki      = spid_pkg::gain_t'(data);
      spid_pkg::CFG_GAIN_D:         kd      = spid_pkg::gain_t'(data);
      spid_pkg::CFG_INTEGRAL_LIMIT: int_lim = data[spid_pkg::LIM_W-1:0];
      spid_pkg::CFG_PULSE_MIN:      pmin    = data[spid_pkg::LIM_W-1:0];
      spid_pkg::CFG_PULSE_MAX:      pmax    = data[spid_pkg::LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Presents one item, after a random number of idle cycles if the current
  // phase asks for sender gaps. Valid stays high after acceptance: the next
  // call either replaces the payload or drops valid at the following falling
  // edge, so valid gets at most one assignment per time step.
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.setpoint_x   <= s.setpoint_x;
    in_if.setpoint_y   <= s.setpoint_y;
    in_if.measured_x   <= s.measured_x;
    in_if.measured_y   <= s.measured_y;
    in_if.last_pulse_x <= s.last_pulse_x;
    in_if.last_pulse_y <= s.last_pulse_y;
    do @(posedge clk); while (!in_if.ready);
    last_expected = predict_pulses(s);
    expected_pulses.push_back(last_expected);
  endtask

  task automatic write_reg(input logic [spid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [spid_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    shadow_reg_write(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes all six registers. The 12-bit ones get random junk in the upper
  // data bits, which the block must ignore.
  task automatic load_config(input spid_pkg::gain_t p, input spid_pkg::gain_t i,
                             input spid_pkg::gain_t d, input spid_pkg::lim_t lim,
                             input spid_pkg::lim_t lo, input spid_pkg::lim_t hi);
    logic [spid_pkg::CFG_DATA_W-spid_pkg::LIM_W-1:0] junk;
    write_reg(spid_pkg::CFG_GAIN_P, p);
    write_reg(spid_pkg::CFG_GAIN_I, i);
    write_reg(spid_pkg::CFG_GAIN_D, d);
    junk = $urandom;
    write_reg(spid_pkg::CFG_INTEGRAL_LIMIT, {junk, lim});
    junk = $urandom;
    write_reg(spid_pkg::CFG_PULSE_MIN, {junk, lo});
    junk = $urandom;
    write_reg(spid_pkg::CFG_PULSE_MAX, {junk, hi});
  endtask

  // Drops valid, waits for every outstanding result, then lets the pipeline
  // settle before any register is touched.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t make_sample(input spid_pkg::coord_t tx, input spid_pkg::coord_t ty,
                                          input spid_pkg::coord_t mx, input spid_pkg::coord_t my,
                                          input spid_pkg::coord_t lx, input spid_pkg::coord_t ly);
    sample_t s;
    s.setpoint_x   = tx;
    s.setpoint_y   = ty;
    s.measured_x   = mx;
    s.measured_y   = my;
    s.last_pulse_x = lx;
    s.last_pulse_y = ly;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Random value pickers
  // ---------------------------------------------------------------------------

  function automatic spid_pkg::gain_t pick_gain();
    case ($urandom_range(9))
      0:       return spid_pkg::gain_t'(32767);
      1:       return spid_pkg::gain_t'(-32768);
      2:       return spid_pkg::gain_t'(0);
      default: return spid_pkg::gain_t'(int'($urandom_range(1024)) - 512);
    endcase
  endfunction

  function automatic spid_pkg::lim_t pick_limit();
    case ($urandom_range(6))
      0:       return spid_pkg::lim_t'(0);
      1:       return spid_pkg::lim_t'(COORD_MAX);
      default: return spid_pkg::lim_t'($urandom);
    endcase
  endfunction

  // Leans toward either an extreme value or a fully random one.
  function automatic spid_pkg::coord_t edge_coord();
    case ($urandom_range(2))
      0:       return '0;
      1:       return COORD_MAX;
      default: return spid_pkg::coord_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No writes yet. The block must come out of reset with gain_p near 0.2,
  // no integral or derivative action, and a pulse window of 500 to 2050.
  task automatic test_reset_values();
    send_sample(make_sample('0, '0, '0, '0, '0, '0));
    send_sample(make_sample(COORD_MAX, COORD_MAX, '0, '0, '0, COORD_MAX));
    send_sample(make_sample('0, '0, COORD_MAX, COORD_MAX, COORD_MAX, '0));
    send_sample(make_sample(12'd2048, 12'd1024, 12'd2048, 12'd1024, 12'd1200, 12'd1300));
  endtask

  // Pure integral action with unity gain, so the pulse shows the integral
  // directly. The integral is clamped on both sides of a tiny limit, held at
  // zero by a zero limit, and saturated at the widest limit.
  task automatic test_integral_clamp();
    wait_idle();
    load_config(spid_pkg::gain_t'(0), spid_pkg::gain_t'(256), spid_pkg::gain_t'(0),
                spid_pkg::lim_t'(3), '0, COORD_MAX);
    send_sample(make_sample(COORD_MAX, COORD_MAX, '0, '0, 12'd2048, 12'd2048));
    send_sample(make_sample(COORD_MAX, COORD_MAX, '0, '0, 12'd2048, 12'd2048));
    send_sample(make_sample('0, '0, COORD_MAX, COORD_MAX, 12'd2048, 12'd2048));
    wait_idle();
    load_config(spid_pkg::gain_t'(0), spid_pkg::gain_t'(256), spid_pkg::gain_t'(0),
                spid_pkg::lim_t'(0), '0, COORD_MAX);
    send_sample(make_sample(COORD_MAX, '0, '0, COORD_MAX, 12'd2048, 12'd2048));
    wait_idle();
    load_config(spid_pkg::gain_t'(0), spid_pkg::gain_t'(256), spid_pkg::gain_t'(0),
                spid_pkg::lim_t'(COORD_MAX), '0, COORD_MAX);
    send_sample(make_sample(COORD_MAX, '0, '0, COORD_MAX, 12'd2048, 12'd2048));
    send_sample(make_sample(COORD_MAX, '0, '0, COORD_MAX, 12'd2048, 12'd2048));
  endtask

  // An inverted window must always give pulse_max. A huge gain must drive one
  // axis below zero and the other past full scale, and both must be clamped.
  task automatic test_pulse_clamp();
    wait_idle();
    load_config(spid_pkg::gain_t'(256), spid_pkg::gain_t'(0), spid_pkg::gain_t'(0),
                spid_pkg::lim_t'(1000), spid_pkg::lim_t'(3000), spid_pkg::lim_t'(1000));
    send_sample(make_sample(12'd2048, 12'd2048, 12'd2048, 12'd2048, '0, COORD_MAX));
    send_sample(make_sample(12'd100, 12'd3000, 12'd900, 12'd10, 12'd2000, 12'd700));
    wait_idle();
    load_config(spid_pkg::gain_t'(32767), spid_pkg::gain_t'(0), spid_pkg::gain_t'(0),
                spid_pkg::lim_t'(1000), '0, COORD_MAX);
    send_sample(make_sample(COORD_MAX, COORD_MAX, '0, '0, 12'd2048, 12'd2048));
    send_sample(make_sample('0, '0, COORD_MAX, COORD_MAX, 12'd2048, 12'd2048));
  endtask

  // Most negative and most positive gains together, with the error swinging
  // between its extremes, so the derivative reaches its full range.
  task automatic test_gain_extremes();
    wait_idle();
    load_config(spid_pkg::gain_t'(-32768), spid_pkg::gain_t'(32767), spid_pkg::gain_t'(-32768),
                spid_pkg::lim_t'(COORD_MAX), '0, COORD_MAX);
    send_sample(make_sample(COORD_MAX, '0, '0, COORD_MAX, 12'd2048, 12'd2048));
    send_sample(make_sample('0, COORD_MAX, COORD_MAX, '0, 12'd2048, 12'd2048));
    send_sample(make_sample(COORD_MAX, '0, '0, COORD_MAX, COORD_MAX, '0));
  endtask

  // Writes to undecoded indexes must change nothing. Upper bits of 12-bit
  // registers must be dropped.
  task automatic test_config_decode();
    wait_idle();
    write_reg(spid_pkg::CFG_GAIN_P, spid_pkg::gain_t'(51));
    write_reg(spid_pkg::CFG_GAIN_I, spid_pkg::gain_t'(0));
    write_reg(spid_pkg::CFG_GAIN_D, spid_pkg::gain_t'(0));
    write_reg(spid_pkg::CFG_INTEGRAL_LIMIT, 16'hFFFF);
    write_reg(spid_pkg::CFG_PULSE_MIN, 16'hA1F4);
    write_reg(spid_pkg::CFG_PULSE_MAX, 16'hF7D0);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h8000);
    send_sample(make_sample(12'd3000, 12'd1000, 12'd1000, 12'd3000, 12'd1500, 12'd1500));
    send_sample(make_sample(12'd10, 12'd4000, 12'd4000, 12'd10, 12'd600, 12'd1900));
  endtask

  // Random traffic under one gap/stall pattern and two register settings.
  // Most items follow a tracking loop: a target that holds for a while, a
  // measurement near it, and the last pulse fed back from the previous
  // result. This lets the integral and derivative build up the way they do
  // in real use. The rest are fully random or extreme fields.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    sample_t          s;
    spid_pkg::coord_t aim_x, aim_y;
    spid_pkg::lim_t   lo, hi;
    int               kind;
    wait_idle();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    aim_x = spid_pkg::coord_t'($urandom);
    aim_y = spid_pkg::coord_t'($urandom);
    for (int half = 0; half < 2; half++) begin
      case ($urandom_range(9))
        0: begin
          lo = spid_pkg::lim_t'($urandom_range(4095, 2048));
          hi = spid_pkg::lim_t'($urandom_range(2047, 0));
        end
        1: begin
          lo = '0;
          hi = spid_pkg::lim_t'(COORD_MAX);
        end
        default: begin
          lo = spid_pkg::lim_t'($urandom_range(1500, 0));
          hi = spid_pkg::lim_t'($urandom_range(4095, 2500));
        end
      endcase
      wait_idle();
      load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), lo, hi);
      for (int n = 0; n < count / 2; n++) begin
        kind = $urandom_range(99);
        if ($urandom_range(9) == 0) begin
          aim_x = spid_pkg::coord_t'($urandom);
          aim_y = spid_pkg::coord_t'($urandom);
        end
        if (kind < 65) begin
          s.setpoint_x   = aim_x;
          s.setpoint_y   = aim_y;
          s.measured_x   = aim_x + spid_pkg::coord_t'(int'($urandom_range(127)) - 64);
          s.measured_y   = aim_y + spid_pkg::coord_t'(int'($urandom_range(127)) - 64);
          s.last_pulse_x = last_expected.pulse_x;
          s.last_pulse_y = last_expected.pulse_y;
        end else if (kind < 85) begin
          s = make_sample(spid_pkg::coord_t'($urandom), spid_pkg::coord_t'($urandom),
                          spid_pkg::coord_t'($urandom), spid_pkg::coord_t'($urandom),
                          spid_pkg::coord_t'($urandom), spid_pkg::coord_t'($urandom));
        end else begin
          s = make_sample(edge_coord(), edge_coord(), edge_coord(),
                          edge_coord(), edge_coord(), edge_coord());
        end
        send_sample(s);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  // Each accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    pulses_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pulses.size() == 0) begin
        $error("unexpected result item: pulse_x %0d, pulse_y %0d",
               out_if.pulse_x, out_if.pulse_y);
        failed = 1'b1;
      end else begin
        want = expected_pulses.pop_front();
        if (out_if.pulse_x !== want.pulse_x) begin
          $error("pulse_x mismatch: expected %0d, actual %0d", want.pulse_x, out_if.pulse_x);
          failed = 1'b1;
        end
        if (out_if.pulse_y !== want.pulse_y) begin
          $error("pulse_y mismatch: expected %0d, actual %0d", want.pulse_y, out_if.pulse_y);
          failed = 1'b1;
        end
      end
    end
  end

  // The receiver decides afresh at every falling edge whether it takes a result.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.setpoint_x   = '0;
    in_if.setpoint_y   = '0;
    in_if.measured_x   = '0;
    in_if.measured_y   = '0;
    in_if.last_pulse_x = '0;
    in_if.last_pulse_y = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    quiet_cycles       = 0;
    failed             = 1'b0;

    // The predictor starts from the block's reset state.
    kp            = spid_pkg::GAIN_P_RST;
    ki            = spid_pkg::GAIN_I_RST;
    kd            = spid_pkg::GAIN_D_RST;
    int_lim       = spid_pkg::INTEGRAL_LIMIT_RST;
    pmin          = spid_pkg::PULSE_MIN_RST;
    pmax          = spid_pkg::PULSE_MAX_RST;
    prev_err[AXIS_X] = '0;
    prev_err[AXIS_Y] = '0;
    integ[AXIS_X]    = '0;
    integ[AXIS_Y]    = '0;
    last_expected    = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed tests run with neither side idling.
    test_reset_values();
    test_integral_clamp();
    test_pulse_clamp();
    test_gain_extremes();
    test_config_decode();

    // Random phases: steady flow, sender gaps, receiver stalls, then both.
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(54, 0, PHASE_ITEMS);
    test_random_traffic(0, 54, PHASE_ITEMS);
    test_random_traffic(35, 35, PHASE_ITEMS);

    wait_idle();
    if (failed) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end

endmodule
